// ----- rtl/kdpq_pkg.sv -----
// Shared types and constants for the key-frame drop packet queue.
package kdpq_pkg;

   localparam int DEPTH_DEFAULT       = 32;
   localparam int HANDLE_BITS_DEFAULT = 32;
   localparam int LIMIT_BITS          = 5;
   localparam int ENTRIES_BITS        = 6;
   localparam int EXT_HANDLE_BITS     = 32;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 5'd31;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      RK_POP  = 2'd0,
      RK_DROP = 2'd1,
      RK_DONE = 2'd2
   } result_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUSH,
      ST_RUN,
      ST_DONE,
      ST_POP
   } state_type;

   typedef struct packed {
      logic                       kind;
      logic [EXT_HANDLE_BITS-1:0] packet_handle;
      logic                       is_key;
   } req_type;

   typedef struct packed {
      result_kind_type            result_kind;
      logic [EXT_HANDLE_BITS-1:0] out_handle;
      logic                       out_key;
      logic                       found;
      logic [ENTRIES_BITS-1:0]    entries_left;
      logic                       last;
   } rsp_type;

   // Classified command handed from the front end to the engine.
   typedef struct packed {
      op_type                     op;
      logic [EXT_HANDLE_BITS-1:0] handle;
      logic                       key;
   } cmd_type;

endpackage

// ----- rtl/kdpq_front.sv -----
// Front end: accepts requests, classifies them and buffers them in a two-entry queue.
module kdpq_front #(
   parameter int HANDLE_BITS = kdpq_pkg::HANDLE_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  kdpq_pkg::req_type req_data,
   output logic              cmd_valid,
   input  logic              cmd_take,
   output kdpq_pkg::cmd_type cmd
);

   localparam logic [kdpq_pkg::EXT_HANDLE_BITS-1:0] HANDLE_MASK =
      (HANDLE_BITS >= kdpq_pkg::EXT_HANDLE_BITS) ? '1 :
      kdpq_pkg::EXT_HANDLE_BITS'((64'(1) << HANDLE_BITS) - 64'(1));

   kdpq_pkg::cmd_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   kdpq_pkg::cmd_type classified;
   logic              do_push;
   logic              do_pop;

   always_comb begin
      classified.op     = req_data.kind ? kdpq_pkg::OP_POP : kdpq_pkg::OP_PUSH;
      classified.handle = req_data.packet_handle & HANDLE_MASK;
      classified.key    = req_data.is_key;
   end

   assign req_full  = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = entry_ff[rd_ptr_ff];
   assign do_push   = req_push && !req_full;
   assign do_pop    = cmd_take && cmd_valid;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

// ----- rtl/kdpq_back.sv -----
// Back end: descriptor storage, head and occupancy tracking, and the drop sequencer.
module kdpq_back #(
   parameter int DEPTH       = kdpq_pkg::DEPTH_DEFAULT,
   parameter int HANDLE_BITS = kdpq_pkg::HANDLE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [kdpq_pkg::LIMIT_BITS-1:0]     packet_limit,
   input  logic                                cmd_valid,
   output logic                                cmd_take,
   input  kdpq_pkg::cmd_type                   cmd,
   output logic                                rsp_push,
   input  logic                                rsp_full,
   output kdpq_pkg::rsp_type                   rsp
);

   localparam int IW = $clog2(DEPTH);
   localparam int OW = $clog2(DEPTH + 1);
   localparam int SW = IW + 1;

   logic [HANDLE_BITS-1:0] mem_hnd [DEPTH];
   logic                   mem_key [DEPTH];

   kdpq_pkg::state_type    state_ff, state_in;
   logic [IW-1:0]          head_ff, head_in;
   logic [OW-1:0]          occ_ff, occ_in;
   logic [HANDLE_BITS-1:0] hnd_ff;
   logic                   key_ff;
   logic                   bypass_ff;
   logic                   full_ff;
   logic [HANDLE_BITS-1:0] rd_hnd_ff;
   logic                   rd_key_ff;

   logic [SW-1:0]          tail_sum;
   logic [IW-1:0]          tail;
   logic [IW-1:0]          head_inc;
   logic [OW-1:0]          occ_dec;
   logic                   is_full;
   logic                   over_limit;
   logic [HANDLE_BITS-1:0] head_hnd;
   logic                   head_key;

   logic                   load_cmd;
   logic                   wr_en;
   logic                   rd_en;
   logic [IW-1:0]          rd_addr;
   logic                   occ_inc;
   logic                   pop_head;
   logic                   emit;

   always_comb begin
      tail_sum   = SW'(head_ff) + SW'(occ_ff);
      tail       = (tail_sum >= SW'(DEPTH)) ? IW'(tail_sum - SW'(DEPTH)) : IW'(tail_sum);
      head_inc   = (head_ff == IW'(DEPTH - 1)) ? '0 : head_ff + IW'(1);
      occ_dec    = occ_ff - OW'(1);
      is_full    = (occ_ff == OW'(DEPTH));
      over_limit = kdpq_pkg::ENTRIES_BITS'(occ_ff) > kdpq_pkg::ENTRIES_BITS'(packet_limit);
      // When the queue was empty the head read raced the write of the new entry.
      head_hnd   = bypass_ff ? hnd_ff : rd_hnd_ff;
      head_key   = bypass_ff ? key_ff : rd_key_ff;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kdpq_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               state_in = (cmd.op == kdpq_pkg::OP_POP) ? kdpq_pkg::ST_POP : kdpq_pkg::ST_PUSH;
            end
         end
         kdpq_pkg::ST_PUSH: begin
            if (!rsp_full) begin
               if (full_ff) begin
                  state_in = kdpq_pkg::ST_DONE;
               end else if (over_limit) begin
                  state_in = head_key ? kdpq_pkg::ST_DONE : kdpq_pkg::ST_RUN;
               end else begin
                  state_in = kdpq_pkg::ST_IDLE;
               end
            end
         end
         kdpq_pkg::ST_RUN: begin
            if (!rsp_full && !(occ_ff != '0 && !rd_key_ff)) begin
               state_in = kdpq_pkg::ST_IDLE;
            end
         end
         kdpq_pkg::ST_DONE, kdpq_pkg::ST_POP: begin
            if (!rsp_full) begin
               state_in = kdpq_pkg::ST_IDLE;
            end
         end
         default: state_in = kdpq_pkg::ST_IDLE;
      endcase
   end

   // Outputs and datapath controls.
   always_comb begin
      cmd_take = 1'b0;
      load_cmd = 1'b0;
      wr_en    = 1'b0;
      rd_en    = 1'b0;
      rd_addr  = head_ff;
      occ_inc  = 1'b0;
      pop_head = 1'b0;
      emit     = 1'b0;
      rsp      = '0;
      case (state_ff)
         kdpq_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1;
               load_cmd = 1'b1;
               rd_en    = 1'b1;
               if (cmd.op == kdpq_pkg::OP_PUSH && !is_full) begin
                  wr_en   = 1'b1;
                  occ_inc = 1'b1;
               end
            end
         end
         kdpq_pkg::ST_PUSH: begin
            emit = 1'b1;
            if (full_ff) begin
               rsp.result_kind  = kdpq_pkg::RK_DROP;
               rsp.out_handle   = kdpq_pkg::EXT_HANDLE_BITS'(hnd_ff);
               rsp.out_key      = key_ff;
               rsp.entries_left = kdpq_pkg::ENTRIES_BITS'(occ_ff);
            end else if (over_limit) begin
               rsp.result_kind  = kdpq_pkg::RK_DROP;
               rsp.out_handle   = kdpq_pkg::EXT_HANDLE_BITS'(head_hnd);
               rsp.out_key      = head_key;
               rsp.entries_left = kdpq_pkg::ENTRIES_BITS'(occ_dec);
               pop_head         = !rsp_full;
               rd_en            = !rsp_full;
               rd_addr          = head_inc;
            end else begin
               rsp.result_kind  = kdpq_pkg::RK_DONE;
               rsp.entries_left = kdpq_pkg::ENTRIES_BITS'(occ_ff);
               rsp.last         = 1'b1;
            end
         end
         kdpq_pkg::ST_RUN: begin
            emit = 1'b1;
            if (occ_ff != '0 && !rd_key_ff) begin
               rsp.result_kind  = kdpq_pkg::RK_DROP;
               rsp.out_handle   = kdpq_pkg::EXT_HANDLE_BITS'(rd_hnd_ff);
               rsp.out_key      = rd_key_ff;
               rsp.entries_left = kdpq_pkg::ENTRIES_BITS'(occ_dec);
               pop_head         = !rsp_full;
               rd_en            = !rsp_full;
               rd_addr          = head_inc;
            end else begin
               rsp.result_kind  = kdpq_pkg::RK_DONE;
               rsp.entries_left = kdpq_pkg::ENTRIES_BITS'(occ_ff);
               rsp.last         = 1'b1;
            end
         end
         kdpq_pkg::ST_DONE: begin
            emit             = 1'b1;
            rsp.result_kind  = kdpq_pkg::RK_DONE;
            rsp.entries_left = kdpq_pkg::ENTRIES_BITS'(occ_ff);
            rsp.last         = 1'b1;
         end
         kdpq_pkg::ST_POP: begin
            emit            = 1'b1;
            rsp.result_kind = kdpq_pkg::RK_POP;
            rsp.last        = 1'b1;
            if (occ_ff != '0) begin
               rsp.out_handle   = kdpq_pkg::EXT_HANDLE_BITS'(rd_hnd_ff);
               rsp.out_key      = rd_key_ff;
               rsp.found        = 1'b1;
               rsp.entries_left = kdpq_pkg::ENTRIES_BITS'(occ_dec);
               pop_head         = !rsp_full;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   assign rsp_push = emit && !rsp_full;

   always_comb begin
      head_in = pop_head ? head_inc : head_ff;
      if (occ_inc) begin
         occ_in = occ_ff + OW'(1);
      end else if (pop_head) begin
         occ_in = occ_dec;
      end else begin
         occ_in = occ_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kdpq_pkg::ST_IDLE;
         head_ff  <= '0;
         occ_ff   <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         occ_ff   <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_cmd) begin
         hnd_ff    <= HANDLE_BITS'(cmd.handle);
         key_ff    <= cmd.key;
         bypass_ff <= (occ_ff == '0);
         full_ff   <= is_full;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_hnd[tail] <= HANDLE_BITS'(cmd.handle);
         mem_key[tail] <= cmd.key;
      end
      if (rd_en) begin
         rd_hnd_ff <= mem_hnd[rd_addr];
         rd_key_ff <= mem_key[rd_addr];
      end
   end

endmodule

// ----- rtl/kdpq_rsp_queue.sv -----
// Two-entry result queue between the engine and the result port.
module kdpq_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_push,
   output logic              in_full,
   input  kdpq_pkg::rsp_type in_data,
   output logic              out_empty,
   input  logic              out_pop,
   output kdpq_pkg::rsp_type out_data
);

   kdpq_pkg::rsp_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign in_full   = (count_ff == 2'd2);
   assign out_empty = (count_ff == 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign do_push   = in_push && !in_full;
   assign do_pop    = out_pop && !out_empty;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// ----- rtl/keyframe_drop_packet_queue_core.sv -----
// Top level of the key-frame drop packet queue: front end, engine, result queue, limit register.
// The engine takes one transaction at a time and emits its results one by one, holding while
// the result queue is full; a pop or a push without drops makes one result, and each dropped
// descriptor adds one more.
// Reset is synchronous: it empties both queues, zeroes head and occupancy and sets the limit
// to 31; the descriptor storage is not cleared, as only written entries are ever read.
module keyframe_drop_packet_queue_core #(
   parameter int DEPTH       = kdpq_pkg::DEPTH_DEFAULT,
   parameter int HANDLE_BITS = kdpq_pkg::HANDLE_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request channel: a transaction is taken when push is high and full is low.
   input  logic                            req_push,
   output logic                            req_full,
   input  kdpq_pkg::req_type               req_data,
   // Result channel: the oldest result is shown while empty is low.
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output kdpq_pkg::rsp_type               rsp_data,
   // Packet limit register write channel.
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [kdpq_pkg::LIMIT_BITS-1:0] csr_wdata
);

   logic [kdpq_pkg::LIMIT_BITS-1:0] packet_limit_ff;
   logic [kdpq_pkg::LIMIT_BITS-1:0] packet_limit_in;

   logic              cmd_valid;
   logic              cmd_take;
   kdpq_pkg::cmd_type cmd;
   logic              eng_push;
   logic              eng_full;
   kdpq_pkg::rsp_type eng_rsp;

   // The limit register is always writable; writes are only expected while the block is idle.
   assign csr_ready       = 1'b1;
   assign packet_limit_in = (csr_valid && csr_ready) ? csr_wdata : packet_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         packet_limit_ff <= kdpq_pkg::LIMIT_RESET;
      end else begin
         packet_limit_ff <= packet_limit_in;
      end
   end

   // The front end decodes push versus pop and masks the handle to the stored width, then
   // holds up to two commands so the request side keeps flowing while the engine drops.
   kdpq_front #(
      .HANDLE_BITS (HANDLE_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take),
      .cmd       (cmd)
   );

   // The engine owns the circular descriptor store. A push into a full store drops the new entry;
   // else it appends, checks the count against the limit, drops a key-frame head or walks a run of
   // non-key entries off the head, one per cycle unless stalled, emitting each dropped descriptor.
   kdpq_back #(
      .DEPTH       (DEPTH),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .packet_limit (packet_limit_ff),
      .cmd_valid    (cmd_valid),
      .cmd_take     (cmd_take),
      .cmd          (cmd),
      .rsp_push     (eng_push),
      .rsp_full     (eng_full),
      .rsp          (eng_rsp)
   );

   // Results are buffered so the engine can keep working while the consumer stalls.
   kdpq_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .in_push   (eng_push),
      .in_full   (eng_full),
      .in_data   (eng_rsp),
      .out_empty (rsp_empty),
      .out_pop   (rsp_pop),
      .out_data  (rsp_data)
   );

endmodule
